// ===== src/imc_pkg.sv =====
// Shared types, widths and constants for the interval medoid cost block.
package imc_pkg;

	// Field widths fixed by the item formats
	localparam int OP_W    = 2;
	localparam int IDX_W   = 10;
	localparam int FIELD_W = 16;
	localparam int LEN_W   = 7;
	localparam int CNT_W   = 11;
	localparam int COST_W  = 48;

	// Defaults for the top-level parameters
	localparam int DEF_MAX_POINTS = 1024;
	localparam int DEF_MAX_WINDOW = 64;
	localparam int DEF_COORD_BITS = 16;

	localparam logic [COST_W-1:0] COST_MAX = '1;

	// Operation codes
	localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
	localparam logic [OP_W-1:0] OP_END   = 2'd1;
	localparam logic [OP_W-1:0] OP_START = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]           operation;
		logic [IDX_W-1:0]          point_index;
		logic signed [FIELD_W-1:0] coord_x;
		logic signed [FIELD_W-1:0] coord_y;
		logic [LEN_W-1:0]          max_length;
	} in_item_t;

	typedef struct packed {
		logic [LEN_W-1:0]  window_length;
		logic [COST_W-1:0] cost;
		logic              infinite;
		logic              last;
	} out_item_t;

endpackage

// ===== src/imc_store.sv =====
// Point store: one write port, one read port with registered read data.
module imc_store import imc_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS,
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic                                clk,
	input  logic                                wr_en,
	input  logic [$clog2(MAX_POINTS)-1:0]       wr_addr,
	input  logic [2*COORD_BITS-1:0]             wr_data,
	input  logic                                rd_en,
	input  logic [$clog2(MAX_POINTS)-1:0]       rd_addr,
	output logic [2*COORD_BITS-1:0]             rd_data
);

	logic [2*COORD_BITS-1:0] mem_q [MAX_POINTS];

	// Write a loaded point
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read: data appears in the cycle after rd_en
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== src/imc_dist.sv =====
// Squared-distance pipeline: difference, square, accumulate against a held medoid.
module imc_dist import imc_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS,
	parameter int SUM_W      = 2*DEF_COORD_BITS+9
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  logic                          pt_valid,
	input  logic signed [COORD_BITS-1:0]  px,
	input  logic signed [COORD_BITS-1:0]  py,
	input  logic signed [COORD_BITS-1:0]  mx,
	input  logic signed [COORD_BITS-1:0]  my,
	output logic                          busy,
	output logic [SUM_W-1:0]              acc
);

	logic                          v_s2, v_s3;
	logic signed [COORD_BITS:0]    dx_s2, dy_s2;
	logic signed [2*COORD_BITS+1:0] sx_s3, sy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= pt_valid;
			v_s3 <= v_s2;
		end
	end

	// Form differences, then squares
	always_ff @(posedge clk) begin
		dx_s2 <= (COORD_BITS+1)'(px) - (COORD_BITS+1)'(mx);
		dy_s2 <= (COORD_BITS+1)'(py) - (COORD_BITS+1)'(my);
		sx_s3 <= dx_s2 * dx_s2;
		sy_s3 <= dy_s2 * dy_s2;
	end

	// Accumulate the window sum for the current medoid
	always_ff @(posedge clk) begin
		if (clear) begin
			acc <= '0;
		end else if (v_s3) begin
			acc <= acc + SUM_W'($unsigned(sx_s3)) + SUM_W'($unsigned(sy_s3));
		end
	end

	assign busy = v_s2 | v_s3;

endmodule

// ===== src/interval_medoid_cost.sv =====
// Top level: item handshakes, window sequencer and result register.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_stall   | in_data  (in_item_t)
//  out     | output    | out_valid / out_stall | out_data (out_item_t)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_data (point_count)
//
// A load item in range is written to the store as it is accepted. A compute item walks window
// lengths 1..max_length, clamped to MAX_WINDOW; for a fitting window of L>1 points, each
// medoid candidate is read, then the window streams from the single read port of the
// point store (one point per cycle per medoid candidate); an infinite or single-point window goes straight to output.
// in_stall is high from acceptance of a compute item until its last result leaves.
// Reset clears the sequencer, the result valid and point_count; the store is not cleared.
// A stalled result holds the sequencer in place.
module interval_medoid_cost import imc_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS,
	parameter int MAX_WINDOW = DEF_MAX_WINDOW,
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data
);

	localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int SUM_W = 2*COORD_BITS + 9;
	localparam int WIDE  = (SUM_W > COST_W) ? SUM_W : COST_W;
	localparam int EXT   = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;
	localparam int NW    = 18;
	localparam logic [NW-1:0]    NMAX = NW'(MAX_POINTS);
	localparam logic [LEN_W-1:0] WMAX = LEN_W'(MAX_WINDOW);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_WIN   = 8'b0000_0010,
		S_RDM   = 8'b0000_0100,
		S_WTM   = 8'b0000_1000,
		S_RUN   = 8'b0001_0000,
		S_DRAIN = 8'b0010_0000,
		S_CMP   = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         count_q;
	logic [OP_W-1:0]          op_q;
	logic [IDX_W-1:0]         idx_q;
	logic [LEN_W-1:0]         maxlen_q, len_q, m_q, k_q;
	logic [AW-1:0]            first_q;
	logic signed [COORD_BITS-1:0] mx_q, my_q;
	logic [SUM_W-1:0]         best_q;
	logic                     rv_s1;
	out_item_t                out_q;
	logic                     out_valid_q;

	logic                     in_acc, out_acc;
	logic [LEN_W-1:0]         maxlen_c;
	logic [NW-1:0]            n_c, idx_w, len_w, first_w;
	logic                     fits_c;
	logic [EXT-1:0]           wx, wy;
	logic                     wr_en, rd_en;
	logic [AW-1:0]            rd_addr;
	logic [2*COORD_BITS-1:0]  rd_data;
	logic                     dist_busy;
	logic [SUM_W-1:0]         acc;
	logic [SUM_W-1:0]         cand_c;
	logic [COST_W-1:0]        sat_c;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_acc   = out_valid_q && !out_stall;

	// Clamp requested lengths and the point count
	assign maxlen_c = (in_data.max_length > WMAX) ? WMAX : in_data.max_length;
	assign n_c      = (NW'(count_q) > NMAX) ? NMAX : NW'(count_q);
	assign idx_w    = NW'(idx_q);
	assign len_w    = NW'(len_q);

	// Decide whether the current window fits and where it starts
	always_comb begin
		if (op_q == OP_END) begin
			fits_c  = (idx_w < n_c) && (len_w <= idx_w + NW'(1));
			first_w = idx_w + NW'(1) - len_w;
		end else begin
			fits_c  = (len_w <= n_c);
			first_w = '0;
		end
	end

	// Load path: zero-extend the coordinates from FIELD_W; the store keeps the low COORD_BITS
	assign wx    = EXT'($unsigned(in_data.coord_x));
	assign wy    = EXT'($unsigned(in_data.coord_y));
	assign wr_en = in_acc && (in_data.operation == OP_LOAD) &&
	               (NW'(in_data.point_index) < NMAX);

	assign rd_en   = (state_q == S_RDM) || (state_q == S_RUN);
	assign rd_addr = (state_q == S_RDM) ? AW'(NW'(first_q) + NW'(m_q))
	                                    : AW'(NW'(first_q) + NW'(k_q));

	imc_store #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(in_data.point_index)),
		.wr_data ({wx[COORD_BITS-1:0], wy[COORD_BITS-1:0]}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	imc_dist #(
		.COORD_BITS(COORD_BITS),
		.SUM_W     (SUM_W)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (state_q == S_WTM),
		.pt_valid (rv_s1),
		.px       ($signed(rd_data[2*COORD_BITS-1:COORD_BITS])),
		.py       ($signed(rd_data[COORD_BITS-1:0])),
		.mx       (mx_q),
		.my       (my_q),
		.busy     (dist_busy),
		.acc      (acc)
	);

	// Keep the smaller sum, then saturate
	assign cand_c = ((m_q == '0) || (acc < best_q)) ? acc : best_q;
	assign sat_c  = (WIDE'(cand_c) > WIDE'(COST_MAX)) ? COST_MAX : COST_W'(cand_c);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			count_q <= cfg_data;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			rv_s1       <= 1'b0;
		end else begin
			rv_s1 <= (state_q == S_RUN);
			if (out_acc) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc && (in_data.operation == OP_END ||
					               in_data.operation == OP_START) && maxlen_c != '0) begin
						state_q <= S_WIN;
					end
				end
				S_WIN: begin
					if (!fits_c || len_q == LEN_W'(1)) begin
						out_valid_q <= 1'b1;
						state_q     <= S_OUT;
					end else begin
						state_q <= S_RDM;
					end
				end
				S_RDM:   state_q <= S_WTM;
				S_WTM:   state_q <= S_RUN;
				S_RUN: begin
					if (k_q == len_q - LEN_W'(1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!rv_s1 && !dist_busy) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (m_q == len_q - LEN_W'(1)) begin
						out_valid_q <= 1'b1;
						state_q     <= S_OUT;
					end else begin
						state_q <= S_RDM;
					end
				end
				S_OUT: begin
					if (out_acc) begin
						state_q <= out_q.last ? S_IDLE : S_WIN;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item and window registers, result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q     <= in_data.operation;
				idx_q    <= in_data.point_index;
				maxlen_q <= maxlen_c;
				len_q    <= LEN_W'(1);
			end
			S_WIN: begin
				first_q <= AW'(first_w);
				m_q     <= '0;
				out_q.window_length <= len_q;
				out_q.last          <= (len_q == maxlen_q);
				out_q.infinite      <= !fits_c;
				out_q.cost          <= fits_c ? '0 : COST_MAX;
			end
			S_WTM: begin
				mx_q <= $signed(rd_data[2*COORD_BITS-1:COORD_BITS]);
				my_q <= $signed(rd_data[COORD_BITS-1:0]);
				k_q  <= '0;
			end
			S_RUN: k_q <= k_q + LEN_W'(1);
			S_CMP: begin
				best_q     <= cand_c;
				m_q        <= m_q + LEN_W'(1);
				out_q.cost <= sat_c;
			end
			S_OUT: begin
				if (out_acc) begin
					len_q <= len_q + LEN_W'(1);
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for interval_medoid_cost: predicted window costs against the block.
module tb_top;
	import imc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int STORE_DEPTH = DEF_MAX_POINTS;
	localparam int WINDOW_CAP = DEF_MAX_WINDOW;
	localparam int FILLED = 64;
	localparam int QUIET_LIMIT = 40000;

	// Expected window costs and the point store they are worked out from
	class medoid_cost_board;
		int px[STORE_DEPTH];
		int py[STORE_DEPTH];
		int unsigned points_used;
		out_item_t costs_due[$];
		int errors;

		function void set_count(logic [CNT_W-1:0] v);
			points_used = (v > STORE_DEPTH) ? STORE_DEPTH : v;
		endfunction

		function logic [COST_W-1:0] window_cost(int first, int len);
			longint unsigned best;
			longint unsigned sum;
			longint dx;
			longint dy;
			best = '1;
			if (len <= 1)
				return '0;
			for (int m = first; m < first + len; m++) begin
				sum = 0;
				for (int k = first; k < first + len; k++) begin
					dx = px[k] - px[m];
					dy = py[k] - py[m];
					sum += dx * dx + dy * dy;
				end
				if (sum < best)
					best = sum;
			end
			return (best > COST_MAX) ? COST_MAX : best[COST_W-1:0];
		endfunction

		// Note one accepted item: load a point, or queue the costs it asks for
		function void note_item(in_item_t it);
			int span;
			bit fits;
			out_item_t r;
			if (it.operation == OP_LOAD) begin
				px[it.point_index] = it.coord_x;
				py[it.point_index] = it.coord_y;
				return;
			end
			if (it.operation == OP_UNUSED)
				return;
			span = (it.max_length > WINDOW_CAP) ? WINDOW_CAP : it.max_length;
			for (int len = 1; len <= span; len++) begin
				if (it.operation == OP_END)
					fits = (it.point_index < points_used) && (len <= it.point_index + 1);
				else
					fits = (len <= points_used);
				r.window_length = LEN_W'(len);
				r.infinite = !fits;
				r.last = (len == span);
				if (!fits)
					r.cost = COST_MAX;
				else if (it.operation == OP_END)
					r.cost = window_cost(it.point_index + 1 - len, len);
				else
					r.cost = window_cost(0, len);
				costs_due.push_back(r);
			end
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			errors++;
		endtask

		// Compare one accepted result with the oldest expectation
		task check_result(out_item_t got);
			out_item_t want;
			if (costs_due.size() == 0) begin
				report($sformatf("unexpected result length %0d", got.window_length));
				return;
			end
			want = costs_due.pop_front();
			if (got.window_length !== want.window_length)
				report($sformatf("window_length %0d, want %0d",
					got.window_length, want.window_length));
			if (got.cost !== want.cost)
				report($sformatf("cost %0d, want %0d (length %0d)",
					got.cost, want.cost, want.window_length));
			if (got.infinite !== want.infinite)
				report($sformatf("infinite %0b, want %0b (length %0d)",
					got.infinite, want.infinite, want.window_length));
			if (got.last !== want.last)
				report($sformatf("last %0b, want %0b (length %0d)",
					got.last, want.last, want.window_length));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CNT_W-1:0] cfg_data;

	medoid_cost_board board;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_off;
	int quiet_cycles;

	interval_medoid_cost dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: stall at random, or hold off for a long stretch on request
	always @(negedge clk) begin
		out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
	end

	// Check results and watch for a stuck run
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check_result(out_data);
			if ((out_valid && !out_stall) || (in_valid && !in_stall)
					|| (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one item after a random gap and hold it until taken
	task send_item(in_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_item(it);
	endtask

	task drop_valid();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task wait_drained();
		while (board.costs_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Write point_count once the block is idle
	task write_count(int v);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= CNT_W'(v);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.set_count(CNT_W'(v));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function in_item_t make_item(logic [OP_W-1:0] op, int idx, int x, int y, int len);
		in_item_t it;
		it.operation = op;
		it.point_index = IDX_W'(idx);
		it.coord_x = FIELD_W'(x);
		it.coord_y = FIELD_W'(y);
		it.max_length = LEN_W'(len);
		return it;
	endfunction

	// Random item: loads and mostly short windows, anchors often inside the set
	function in_item_t random_item();
		in_item_t it;
		int pick;
		it = make_item(OP_LOAD, $urandom_range(STORE_DEPTH - 1), $urandom, $urandom, 0);
		it.max_length = LEN_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 40)
			it.operation = OP_LOAD;
		else if (pick < 75)
			it.operation = OP_END;
		else if (pick < 95)
			it.operation = OP_START;
		else
			it.operation = OP_UNUSED;
		if (it.operation != OP_LOAD) begin
			it.max_length = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(24))
			                                         : LEN_W'($urandom_range(10));
			if (board.points_used > 0 && $urandom_range(2) != 0)
				it.point_index = IDX_W'($urandom_range(board.points_used - 1));
		end
		return it;
	endfunction

	task random_phase(int idle_pct, int stall_pct, int count, int items);
		write_count(count);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (items)
			send_item(random_item());
		drop_valid();
		wait_drained();
	endtask

	initial begin
		board = new();
		board.set_count(0);
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 1'b0;
		quiet_cycles = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Empty set: every window infinite, zero length and unused code give nothing
		send_item(make_item(OP_START, 0, 0, 0, 3));
		send_item(make_item(OP_END, 5, 0, 0, 2));
		send_item(make_item(OP_END, 0, 0, 0, 0));
		send_item(make_item(OP_UNUSED, 1023, -1, -1, 127));

		// Fill the prefix that every window below stays within
		for (int i = 0; i < FILLED; i++)
			send_item(make_item(OP_LOAD, i, $urandom, $urandom, 0));
		send_item(make_item(OP_LOAD, 0, -32768, 32767, 0));
		send_item(make_item(OP_LOAD, 1, 32767, -32768, 0));
		send_item(make_item(OP_LOAD, 2, -32768, -32768, 0));
		send_item(make_item(OP_LOAD, FILLED - 1, 32767, 32767, 0));
		drop_valid();

		// Short set: partly fitting windows and an anchor beyond the count
		write_count(5);
		send_item(make_item(OP_END, 4, 0, 0, 8));
		send_item(make_item(OP_END, 2, 0, 0, 4));
		send_item(make_item(OP_START, 0, 0, 0, 7));
		send_item(make_item(OP_END, 7, 0, 0, 3));
		drop_valid();

		// Count above the store size and the longest windows
		write_count((1 << CNT_W) - 1);
		send_item(make_item(OP_START, 0, 0, 0, 127));
		send_item(make_item(OP_END, FILLED - 1, 0, 0, 64));
		drop_valid();

		// A single point costs nothing
		write_count(1);
		send_item(make_item(OP_START, 0, 0, 0, 2));
		send_item(make_item(OP_END, 0, 0, 0, 1));
		drop_valid();

		random_phase(0, 0, FILLED, 50);
		random_phase(61, 0, 37, 50);

		// Hold the receiver off while items keep coming
		write_count(60);
		send_idle_pct = 0;
		recv_stall_pct = 61;
		fork
			begin
				hold_off = 1'b1;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
		join_none
		repeat (50)
			send_item(random_item());
		drop_valid();
		wait_drained();

		random_phase(28, 28, $urandom_range(FILLED), 50);
		write_count(0);

		wait_drained();
		repeat (50) @(posedge clk);
		if (board.errors == 0 && board.costs_due.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/imc_pkg.sv
src/imc_store.sv
src/imc_dist.sv
src/interval_medoid_cost.sv
tb/tb_top.sv
